// File: rtl/sirt_pkg.sv
package sirt_pkg;

    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int NUM_CHARS  = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_BITS  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_CTRL_LO = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CTRL_HI = 8'd13;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } t_div_stat;

endpackage

// File: rtl/sirt_alpha_chk.sv
module sirt_alpha_chk #(
    parameter int MAX_RADIX = 16
) (
    input  logic [sirt_pkg::RADIX_W-1:0]    i_radix,
    input  logic [sirt_pkg::CFG_DATA_W-1:0] i_chars_low,
    input  logic [sirt_pkg::CFG_DATA_W-1:0] i_chars_high,
    output logic                            o_ok
);

    logic [sirt_pkg::CHAR_W-1:0] w_chars [sirt_pkg::NUM_CHARS];

    always_comb begin
        for (int k = 0; k < sirt_pkg::NUM_CHARS / 2; k++) begin
            w_chars[k]                           = i_chars_low[k*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
            w_chars[k + sirt_pkg::NUM_CHARS / 2] = i_chars_high[k*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
        end
    end

    always_comb begin
        logic bad;
        logic [sirt_pkg::CHAR_W-1:0] c;
        bad = (i_radix < sirt_pkg::RADIX_W'(2))
           || (i_radix > sirt_pkg::RADIX_W'(MAX_RADIX))
           || (i_radix > sirt_pkg::RADIX_W'(sirt_pkg::NUM_CHARS));
        for (int i = 0; i < sirt_pkg::NUM_CHARS; i++) begin
            c = w_chars[i];
            if (sirt_pkg::RADIX_W'(i) < i_radix) begin
                if (c == sirt_pkg::CHAR_NUL || c == sirt_pkg::CHAR_PLUS ||
                    c == sirt_pkg::CHAR_MINUS || c == sirt_pkg::CHAR_SPACE ||
                    (c >= sirt_pkg::CHAR_CTRL_LO && c <= sirt_pkg::CHAR_CTRL_HI)) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < sirt_pkg::NUM_CHARS; j++) begin
                    if (sirt_pkg::RADIX_W'(j) < i_radix && w_chars[j] == c) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        o_ok = !bad;
    end

endmodule

// File: rtl/sirt_div.sv
module sirt_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_WIDTH-1:0]       i_dividend,
    input  logic [sirt_pkg::RADIX_W-1:0] i_divisor,
    output logic [VALUE_WIDTH-1:0]       o_quotient,
    output sirt_pkg::t_div_stat          o_stat
);

    localparam int NCYC = (VALUE_WIDTH + sirt_pkg::STEP_BITS - 1) / sirt_pkg::STEP_BITS;
    localparam int PW   = NCYC * sirt_pkg::STEP_BITS;
    localparam int CW   = $clog2(NCYC + 1);

    logic [PW-1:0]                r_work, n_work;
    logic [sirt_pkg::DIGIT_W-1:0] r_rem, n_rem;
    logic [CW-1:0]                r_cnt;
    logic                         r_busy;
    logic                         r_done;

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb begin
        logic [PW-1:0]                w;
        logic [sirt_pkg::DIGIT_W-1:0] rm;
        logic [sirt_pkg::RADIX_W-1:0] t;
        w = r_work;
        rm = r_rem;
        for (int i = 0; i < sirt_pkg::STEP_BITS; i++) begin
            t = {rm, w[PW-1]};
            w = {w[PW-2:0], 1'b0};
            if (t >= i_divisor) begin
                w[0] = 1'b1;
                t = t - i_divisor;
            end
            rm = t[sirt_pkg::DIGIT_W-1:0];
        end
        n_work = w;
        n_rem = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NCYC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= PW'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_work[VALUE_WIDTH-1:0];
    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

// File: rtl/signed_int_to_radix_text_unit.sv
// channel  direction  handshake                   payload
// in       sink       i_in_valid / o_in_ready     i_value
// out      source     o_out_valid / i_out_ready   o_text_byte, o_last
// cfg      sink       i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// Each digit is produced by the shared divider, eight quotient bits per
// cycle; each digit character then passes through the digit store read,
// the alphabet lookup and the output register, and waits out any stall;
// the minus sign goes straight to the output register.
// Reset clears the sequencer, counters and configuration; the digit store
// is not cleared. No new word is taken until the last character has gone.
module signed_int_to_radix_text_unit #(
    parameter int MAX_RADIX   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sirt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0]   i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sirt_pkg::CHAR_W-1:0]     o_text_byte,
    output logic                            o_last
);

    localparam int AW   = $clog2(VALUE_WIDTH);
    localparam int CNTW = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [sirt_pkg::RADIX_W-1:0]    r_radix;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_chars_low;
    logic [sirt_pkg::CFG_DATA_W-1:0] r_chars_high;

    logic [2:0]                   r_state, n_state;
    logic [CNTW-1:0]              r_cnt, n_cnt;
    logic                         r_neg, n_neg;
    logic                         r_out_valid, n_out_valid;
    logic [sirt_pkg::CHAR_W-1:0]  r_out_byte, n_out_byte;
    logic                         r_last, n_last;
    logic [sirt_pkg::DIGIT_W-1:0] r_store [VALUE_WIDTH];
    logic [sirt_pkg::DIGIT_W-1:0] r_rd_digit;

    logic                         w_ok;
    logic                         w_accept;
    logic                         w_start;
    logic [VALUE_WIDTH-1:0]       w_mag;
    logic [VALUE_WIDTH-1:0]       w_dividend;
    logic [VALUE_WIDTH-1:0]       w_quotient;
    sirt_pkg::t_div_stat          w_div;
    logic                         w_wr;
    logic [CNTW-1:0]              w_cnt_inc;
    logic [CNTW-1:0]              w_cnt_dec;
    logic [sirt_pkg::CHAR_W-1:0]  w_char;

    sirt_alpha_chk #(
        .MAX_RADIX (MAX_RADIX)
    ) u_alpha_chk (
        .i_radix      (r_radix),
        .i_chars_low  (r_chars_low),
        .i_chars_high (r_chars_high),
        .o_ok         (w_ok)
    );

    sirt_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_radix),
        .o_quotient (w_quotient),
        .o_stat     (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= '0;
            r_chars_low <= '0;
            r_chars_high <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sirt_pkg::CFG_RADIX:      r_radix <= i_cfg_data[sirt_pkg::RADIX_W-1:0];
                sirt_pkg::CFG_CHARS_LOW:  r_chars_low <= i_cfg_data;
                sirt_pkg::CFG_CHARS_HIGH: r_chars_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_mag      = i_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - i_value) : i_value;
    assign w_cnt_inc  = r_cnt + CNTW'(1);
    assign w_cnt_dec  = r_cnt - CNTW'(1);
    assign w_char     = r_rd_digit[sirt_pkg::DIGIT_W-1]
                      ? r_chars_high[r_rd_digit[sirt_pkg::DIGIT_W-2:0]*sirt_pkg::CHAR_W +:
                                     sirt_pkg::CHAR_W]
                      : r_chars_low[r_rd_digit[sirt_pkg::DIGIT_W-2:0]*sirt_pkg::CHAR_W +:
                                    sirt_pkg::CHAR_W];

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_neg = r_neg;
        n_out_valid = r_out_valid;
        n_out_byte = r_out_byte;
        n_last = r_last;
        w_start = 1'b0;
        w_dividend = w_quotient;
        w_wr = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_dividend = w_mag;
                if (w_accept && w_ok) begin
                    w_start = 1'b1;
                    n_neg = i_value[VALUE_WIDTH-1];
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_wr = 1'b1;
                    n_cnt = w_cnt_inc;
                    if (w_quotient == '0 || w_cnt_inc == CNTW'(VALUE_WIDTH)) begin
                        if (r_neg) begin
                            n_out_byte = sirt_pkg::CHAR_MINUS;
                            n_last = 1'b0;
                            n_out_valid = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        w_start = 1'b1;
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_out_byte = w_char;
                n_last = (r_cnt == CNTW'(1));
                n_out_valid = 1'b1;
                n_cnt = w_cnt_dec;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state = r_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_neg <= 1'b0;
            r_out_valid <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_neg <= n_neg;
            r_out_valid <= n_out_valid;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
    end

    // digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[r_cnt[AW-1:0]] <= w_div.rem;
        end
        r_rd_digit <= r_store[w_cnt_dec[AW-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_text_byte = r_out_byte;
    assign o_last      = r_last;

    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("output word pending while idle");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside division phase");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(VALUE_WIDTH))
        else $error("digit count beyond value width");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("not idle after final character");

    a_bad_alpha_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_ok) |=> (o_in_ready && !o_out_valid))
        else $error("activity after word with invalid alphabet");

endmodule
